### hdl/shifting_fifo_with_search_core_defines.svh
// ----------------------------------------------------------------------------
// shifting fifo with search: assertion macros
// concurrent checks on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef SHIFTING_FIFO_WITH_SEARCH_CORE_DEFINES_SVH
`define SHIFTING_FIFO_WITH_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shifting fifo check failed");
// next-cycle implication
`define SFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shifting fifo check failed");
`else
`define SFS_ASSERT_IMP(lbl, ante, cons)
`define SFS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hdl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// shared types and codes for the shifting fifo with search
// ----------------------------------------------------------------------------
package sfs_pkg;

  typedef enum logic [1:0] {
    FN_ENQ  = 2'd0,
    FN_DEQ  = 2'd1,
    FN_SRCH = 2'd2,
    FN_PEEK = 2'd3
  } func_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic do_op;
    logic do_reduce;
  } cmd_t;

endpackage

### hdl/sfs_ctrl.sv
// ----------------------------------------------------------------------------
// sfs_ctrl
// request sequencer: accept, optional search reduce, hold result
// ----------------------------------------------------------------------------
module sfs_ctrl
  import sfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  output logic       out_valid,
  input  logic       out_stall,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (func_t'(func) == FN_SRCH) ? S_SEARCH : S_DONE;
        end
      end
      S_SEARCH: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd.do_op     = 1'b0;
    cmd.do_reduce = 1'b0;
    case (state)
      S_IDLE: begin
        // no transaction is taken while reset is held
        in_stall  = rst;
        cmd.do_op = in_valid && !rst;
      end
      S_SEARCH: begin
        cmd.do_reduce = 1'b1;
      end
      S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### hdl/sfs_datapath.sv
// ----------------------------------------------------------------------------
// sfs_datapath
// shift-line slots, count, tail copy, per-slot compare lanes, result fields
// ----------------------------------------------------------------------------
module sfs_datapath
  import sfs_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [1:0]         func,
  input  logic signed [31:0] data_value,
  output logic [1:0]         status,
  output logic signed [31:0] removed_value,
  output logic               found,
  output logic signed [31:0] head_value,
  output logic signed [31:0] tail_value,
  output logic [3:0]         occupancy,
  output logic               is_empty,
  output logic               is_full
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = (CW > 4) ? CW : 4;

  logic signed [31:0] slots [DEPTH];
  logic signed [31:0] tail;
  logic [CW-1:0]      count;
  logic [DEPTH-1:0]   hits;
  logic [DEPTH-1:0]   lane_valid;
  logic [EW-1:0]      count_ext;
  logic               cnt_zero;
  logic               cnt_full;

  assign cnt_zero = (count == '0);
  assign cnt_full = (count == CW'(DEPTH));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lane_valid[i] = (CW'(i) < count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_op) begin
      if (func_t'(func) == FN_ENQ && !cnt_full) begin
        count <= count + CW'(1);
      end else if (func_t'(func) == FN_DEQ && !cnt_zero) begin
        count <= count - CW'(1);
      end
    end
  end

  // payload: slots, tail copy, compare lanes, result fields
  always_ff @(posedge clk) begin
    if (cmd.do_op) begin
      status        <= ST_OK;
      removed_value <= '0;
      found         <= 1'b0;
      case (func_t'(func))
        FN_ENQ: begin
          if (cnt_full) begin
            status <= ST_FULL;
          end else begin
            slots[count[IW-1:0]] <= data_value;
            tail                 <= data_value;
          end
        end
        FN_DEQ: begin
          if (cnt_zero) begin
            status <= ST_EMPTY;
          end else begin
            removed_value <= slots[0];
            for (int i = 0; i < DEPTH - 1; i++) begin
              slots[i] <= slots[i + 1];
            end
          end
        end
        FN_SRCH: begin
          if (cnt_zero) begin
            status <= ST_EMPTY;
          end
          for (int i = 0; i < DEPTH; i++) begin
            hits[i] <= lane_valid[i] && (slots[i] == data_value);
          end
        end
        default: begin
          status <= ST_OK;
        end
      endcase
    end else if (cmd.do_reduce) begin
      found <= |hits;
    end
  end

  assign count_ext  = EW'(count);
  assign occupancy  = count_ext[3:0];
  assign is_empty   = cnt_zero;
  assign is_full    = cnt_full;
  assign head_value = cnt_zero ? 32'sd0 : slots[0];
  assign tail_value = cnt_zero ? 32'sd0 : tail;

endmodule

### hdl/shifting_fifo_with_search_core.sv
// ----------------------------------------------------------------------------
// shifting_fifo_with_search_core
// fixed-depth queue with its head in slot 0, dequeue shifts every slot forward
//
// input channel (in_valid / in_stall): func and data_value, one request per
// transaction. output channel (out_valid / out_stall): one result per request,
// giving status, removed value, search hit and the queue after the operation.
// a result is offered the cycle after its request is accepted (a search
// first registers its per-slot compares, then reduces them to the hit in the
// search state before its result is offered); the sequencer holds one request
// at a time, so the next accept follows the cycle after the result is taken.
// while a result waits under out_stall it holds steady and in_stall stays up.
// in_stall is high while rst is held.
// reset empties the queue; slot contents are left as they are.
// ----------------------------------------------------------------------------
`include "shifting_fifo_with_search_core_defines.svh"

module shifting_fifo_with_search_core
  import sfs_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic signed [31:0] data_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] removed_value,
  output logic               found,
  output logic signed [31:0] head_value,
  output logic signed [31:0] tail_value,
  output logic [3:0]         occupancy,
  output logic               is_empty,
  output logic               is_full
);

  cmd_t cmd;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sfs_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .func          (func),
    .data_value    (data_value),
    .status        (status),
    .removed_value (removed_value),
    .found         (found),
    .head_value    (head_value),
    .tail_value    (tail_value),
    .occupancy     (occupancy),
    .is_empty      (is_empty),
    .is_full       (is_full)
  );

  // a result is only presented while new requests are held off
  `SFS_ASSERT_IMP(a_valid_holds_input, out_valid, in_stall)
  // an accepted transaction blocks the input until its result is taken
  `SFS_ASSERT_NXT(a_accept_then_stall, in_valid && !in_stall, in_stall)
  // a rejected enqueue leaves the queue full
  `SFS_ASSERT_IMP(a_full_reject, out_valid && status == ST_FULL, is_full)
  // an empty rejection removes nothing and finds nothing
  `SFS_ASSERT_IMP(a_empty_reject, out_valid && status == ST_EMPTY,
                  is_empty && !found && removed_value == 32'sd0)

endmodule
